// ===== rtl/pps_pkg.sv =====
// Shared types and constants of the pure pursuit steering block.
// Used by the channel interfaces and the top level; depends on nothing.
package pps_pkg;

   // Action codes of the request word
   localparam logic [1:0] ACT_WAYPOINT = 2'd0;
   localparam logic [1:0] ACT_ODOMETRY = 2'd1;
   localparam logic [1:0] ACT_GOAL     = 2'd2;
   localparam logic [1:0] ACT_CRASH    = 2'd3;

   // Control register port
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LA_MIN     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LA_GAIN    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEELBASE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WP_COUNT   = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_WIN = 8'd5;

   // CORDIC constants
   localparam int CORDIC_STEPS = 20;
   localparam logic [23:0] CORDIC_GAIN_Q24 = 24'd10188013;
   localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;

   typedef struct packed {
      logic [1:0]         action;
      logic [9:0]         waypoint_index;
      logic [31:0]        time_ms;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] velocity;
      logic [15:0]        heading;
      logic               flag_value;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] steering;
      logic [14:0]        speed_command;
      logic [9:0]         target_index;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic               forced_stop;
   } rsp_word_type;

   // atan(2^-i) with 2^32 units per turn
   function automatic logic [31:0] atan_turn32(input logic [4:0] i);
      logic [31:0] a;
      unique case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/pps_if.sv =====
// Valid/ready channel interfaces: request, response and control register write.
// Depends on pps_pkg for the word types and port widths.
interface pps_req_if;
   logic                  valid;
   logic                  ready;
   pps_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface pps_rsp_if;
   logic                  valid;
   logic                  ready;
   pps_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface pps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pps_pkg::CSR_IDX_W-1:0]    index;
   logic [pps_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pure_pursuit_steering_with_speed_replay.sv =====
// Pure pursuit path tracker with a waypoint memory and time-replayed speed.
// Depends on pps_pkg and the channel interfaces in pps_if.sv.
//
// Usage:
//  req_ch carries one word per handshake. Waypoint writes and goal/crash flag
//  words are taken while idle and give no response. An odometry word gives one
//  response word on rsp_ch (none when the table is empty and no flag is set).
//  csr_ch writes the control registers; it is always ready and must only be
//  written while the block is idle.
// Processing of an odometry word, with W the search window and n the table count:
//  W entries are searched, then up to n segments are walked (each bound by the
//  29-step square root) and up to n entries scanned for the speed, all through
//  the single table port, read once per step.
//  Words are processed one at a time; req_ch is ready only between words.
//  While a goal or crash flag is set, an odometry word gives a zero forced-stop response.
// rsp_ch has an output register: a new word is accepted while a response waits;
//  the sequencer holds its finished result until the output register is free.
// Reset clears control state and registers to their defaults; the waypoint
//  memory is not cleared and reads undefined until written.
module pure_pursuit_steering_with_speed_replay #(
   parameter int TABLE_DEPTH = 1024
) (
   input logic           clock,
   input logic           reset,
   pps_req_if.sink       req_ch,
   pps_rsp_if.source     rsp_ch,
   pps_csr_if.sink       csr_ch
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = (CW > 11) ? CW : 11;
   localparam int ACW = IW + 30;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [15:0] v;
   } wp_entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MOD, S_SRCH_RD, S_SRCH_MUL, S_SRCH_CMP,
      S_WALK_RD0, S_WALK_PREV, S_WALK_RD, S_WALK_MUL, S_WALK_SUM, S_SQRT, S_WALK_ACC,
      S_TGT_RD, S_TGT, S_L2, S_ROT, S_LYMUL, S_LYSUM, S_NUMMUL, S_NUMSUM,
      S_NORM, S_VEC, S_SPD_RD0, S_SPD_T0, S_SPD_RDL, S_SPD_TL, S_SPD_RD, S_SPD_CMP,
      S_DONE
   } state_type;

   // waypoint memory
   wp_entry_type mem [TABLE_DEPTH];
   logic         mem_we;
   logic [IW-1:0] mem_waddr;
   wp_entry_type mem_wdata;

   state_type state_ff, state_in;
   logic [15:0] la_min_ff, la_min_in, la_gain_ff, la_gain_in, wb_ff, wb_in;
   logic [16:0] max_spd_ff, max_spd_in;
   logic [10:0] wcount_ff, wcount_in, swin_ff, swin_in;
   logic [IW-1:0] last_near_ff, last_near_in;
   logic [31:0] start_time_ff, start_time_in;
   logic started_ff, started_in, goal_ff, goal_in, crash_ff, crash_in;

   logic signed [23:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] vel_ff, vel_in;
   logic [15:0] head_ff, head_in;
   logic [31:0] time_ff, time_in;
   logic [CW-1:0] n_ff, n_in;
   logic [10:0] win_ff, win_in;

   logic [IW-1:0] mod_src_ff, mod_src_in;
   logic [CW-1:0] mod_rem_ff, mod_rem_in;
   logic [IW-1:0] addr_ff, addr_in;
   wp_entry_type rd_q_ff;
   logic [IW-1:0] idx_ff, idx_in, near_ff, near_in, target_ff, target_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic have_ff, have_in;
   logic [50:0] best_ff, best_in, l2_ff, l2_in;
   logic [49:0] sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic signed [23:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [33:0] la_ff, la_in;
   logic [ACW-1:0] acc_ff, acc_in;
   logic [57:0] sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic signed [23:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [24:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [39:0] cx_ff, cx_in, cy_ff, cy_in, ly_ff, ly_in;
   logic signed [33:0] cz_ff, cz_in, vz_ff, vz_in;
   logic [43:0] pp_lo_ff, pp_lo_in;
   logic signed [44:0] pp_hi_ff, pp_hi_in;
   logic [36:0] np_lo_ff, np_lo_in;
   logic signed [37:0] np_hi_ff, np_hi_in;
   logic signed [63:0] vn_ff, vn_in, vd_ff, vd_in;
   logic [31:0] t0_ff, t0_in;
   logic signed [15:0] steer_ff, steer_in;
   logic [14:0] spd_ff, spd_in;
   logic forced_ff, forced_in;
   logic rsp_valid_ff, rsp_valid_in;
   pps_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // shared datapath pieces
   logic signed [23:0] base_x, base_y;
   logic signed [24:0] ex, ey;
   logic signed [49:0] ex_sq, ey_sq;
   logic [50:0] sq_sum;
   logic signed [32:0] la_prod;
   logic signed [33:0] la_calc;
   logic signed [63:0] ly_prod, num_prod, vn_abs;
   logic signed [44:0] gain_mul;
   logic signed [37:0] wb_mul;
   logic [31:0] n_full, elapsed, z_init32;
   logic [CW:0] mod_try;
   logic [57:0] sq_try;
   logic [ACW-1:0] acc_new;
   logic la_hit;
   logic signed [39:0] cx_sh, cy_sh, rx0, ry0;
   logic signed [33:0] cz0, atan_s, zr;
   logic signed [63:0] vd_sh, vn_sh;
   logic search_upd;
   logic [IW-1:0] near_new;

   function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i, input logic [CW-1:0] n);
      return ((CW'(i) + CW'(1)) == n) ? '0 : IW'(CW'(i) + CW'(1));
   endfunction

   // table speed, capped and clamped at zero
   function automatic logic [14:0] cap_speed(input logic signed [15:0] v,
                                              input logic [16:0] cap);
      logic signed [17:0] s;
      s = 18'(v);
      if (cap != '0 && s > $signed({1'b0, cap})) s = $signed({1'b0, cap});
      if (s < 0) s = '0;
      return 15'(s);
   endfunction

   // memory port: one write from the request channel, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[addr_ff];
   end

   assign mem_we = (state_ff == S_IDLE) && req_ch.valid &&
                   (req_ch.word.action == pps_pkg::ACT_WAYPOINT) &&
                   (32'(req_ch.word.waypoint_index) < 32'(TABLE_DEPTH));
   assign mem_waddr = IW'(req_ch.word.waypoint_index);
   assign mem_wdata = '{time_ms: req_ch.word.time_ms, x: req_ch.word.pos_x,
                        y: req_ch.word.pos_y, v: req_ch.word.velocity};

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word = rsp_word_ff;

   // difference and square against the vehicle or the previous waypoint
   assign base_x = (state_ff == S_WALK_MUL) ? prev_x_ff : px_ff;
   assign base_y = (state_ff == S_WALK_MUL) ? prev_y_ff : py_ff;
   assign ex = 25'(rd_q_ff.x) - 25'(base_x);
   assign ey = 25'(rd_q_ff.y) - 25'(base_y);
   assign ex_sq = ex * ex;
   assign ey_sq = ey * ey;
   assign sq_sum = 51'(sq_a_ff) + 51'(sq_b_ff);

   // lookahead in mm Q8
   assign la_prod = $signed({1'b0, la_gain_ff}) * vel_ff;
   assign la_calc = 34'(la_prod) + $signed({10'b0, la_min_ff, 8'b0});

   assign n_full = (32'(wcount_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(wcount_ff);
   assign elapsed = time_ff - start_time_ff;
   assign mod_try = {mod_rem_ff, mod_src_ff[IW-1]};
   assign sq_try = sq_r_ff + sq_bit_ff;
   assign acc_new = acc_ff + ACW'(sq_r_ff);
   assign la_hit = la_ff[33] || ({acc_new, 4'b0} >= (ACW + 4)'(la_ff[32:0]));
   assign search_upd = !have_ff || (sq_sum < best_ff);
   assign near_new = search_upd ? idx_ff : near_ff;

   // rotation setup: exact quarter turn by -heading
   assign z_init32 = 32'd0 - {head_ff, 16'b0};
   always_comb begin
      cz0 = 34'($signed(z_init32));
      rx0 = 40'(dx_ff) <<< 8;
      ry0 = 40'(dy_ff) <<< 8;
      if (cz0 > pps_pkg::QUARTER_TURN) begin
         rx0 = -(40'(dy_ff) <<< 8);
         ry0 = 40'(dx_ff) <<< 8;
         cz0 = cz0 - pps_pkg::QUARTER_TURN;
      end else if (cz0 < -pps_pkg::QUARTER_TURN) begin
         rx0 = 40'(dy_ff) <<< 8;
         ry0 = -(40'(dx_ff) <<< 8);
         cz0 = cz0 + pps_pkg::QUARTER_TURN;
      end
   end

   assign atan_s = $signed({2'b0, pps_pkg::atan_turn32(cnt_ff[4:0])});
   assign cx_sh = cx_ff >>> cnt_ff[4:0];
   assign cy_sh = cy_ff >>> cnt_ff[4:0];
   assign vd_sh = vd_ff >>> cnt_ff[4:0];
   assign vn_sh = vn_ff >>> cnt_ff[4:0];
   assign vn_abs = vn_ff[63] ? -vn_ff : vn_ff;

   // split products: gain correction and the 2*wheelbase factor
   assign gain_mul = $signed(cy_ff[39:20]) * $signed({1'b0, pps_pkg::CORDIC_GAIN_Q24});
   assign wb_mul = $signed(ly_ff[39:20]) * $signed({1'b0, wb_ff, 1'b0});
   assign ly_prod = (64'(pp_hi_ff) <<< 20) + $signed(64'(pp_lo_ff));
   assign num_prod = (64'(np_hi_ff) <<< 20) + $signed(64'(np_lo_ff));

   // sequencer
   always_comb begin
      state_in = state_ff;
      la_min_in = la_min_ff; la_gain_in = la_gain_ff; wb_in = wb_ff;
      max_spd_in = max_spd_ff; wcount_in = wcount_ff; swin_in = swin_ff;
      last_near_in = last_near_ff; start_time_in = start_time_ff;
      started_in = started_ff; goal_in = goal_ff; crash_in = crash_ff;
      px_in = px_ff; py_in = py_ff; vel_in = vel_ff; head_in = head_ff; time_in = time_ff;
      n_in = n_ff; win_in = win_ff;
      mod_src_in = mod_src_ff; mod_rem_in = mod_rem_ff; addr_in = addr_ff;
      idx_in = idx_ff; near_in = near_ff; target_in = target_ff; cnt_in = cnt_ff;
      have_in = have_ff; best_in = best_ff; l2_in = l2_ff;
      sq_a_in = sq_a_ff; sq_b_in = sq_b_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff; la_in = la_ff; acc_in = acc_ff;
      sq_v_in = sq_v_ff; sq_r_in = sq_r_ff; sq_bit_in = sq_bit_ff;
      tx_in = tx_ff; ty_in = ty_ff; dx_in = dx_ff; dy_in = dy_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; ly_in = ly_ff;
      pp_lo_in = pp_lo_ff; pp_hi_in = pp_hi_ff; np_lo_in = np_lo_ff; np_hi_in = np_hi_ff;
      vn_in = vn_ff; vd_in = vd_ff; vz_in = vz_ff; t0_in = t0_ff;
      steer_in = steer_ff; spd_in = spd_ff; forced_in = forced_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in = rsp_word_ff;

      // control register writes
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pps_pkg::CSR_LA_MIN:     la_min_in = csr_ch.data[15:0];
            pps_pkg::CSR_LA_GAIN:    la_gain_in = csr_ch.data[15:0];
            pps_pkg::CSR_WHEELBASE:  wb_in = csr_ch.data[15:0];
            pps_pkg::CSR_MAX_SPEED:  max_spd_in = csr_ch.data[16:0];
            pps_pkg::CSR_WP_COUNT:   wcount_in = csr_ch.data[10:0];
            pps_pkg::CSR_SEARCH_WIN: swin_in = csr_ch.data[10:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               px_in = req_ch.word.pos_x; py_in = req_ch.word.pos_y;
               vel_in = req_ch.word.velocity; head_in = req_ch.word.heading;
               time_in = req_ch.word.time_ms;
               unique case (req_ch.word.action)
                  pps_pkg::ACT_GOAL:  goal_in = req_ch.word.flag_value;
                  pps_pkg::ACT_CRASH: crash_in = req_ch.word.flag_value;
                  pps_pkg::ACT_ODOMETRY: begin
                     if (goal_ff || crash_ff) begin
                        // forced stop: zero command
                        steer_in = '0; spd_in = '0; target_in = '0;
                        tx_in = '0; ty_in = '0; forced_in = 1'b1;
                        state_in = S_DONE;
                     end else if (n_full != 32'd0) begin
                        if (!started_ff) begin
                           start_time_in = req_ch.word.time_ms;
                           started_in = 1'b1;
                        end
                        n_in = CW'(n_full);
                        win_in = (swin_ff == '0) ? 11'd1 : swin_ff;
                        mod_src_in = last_near_ff; mod_rem_in = '0; cnt_in = '0;
                        forced_in = 1'b0;
                        state_in = S_MOD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // start index: last nearest modulo count, one quotient bit a cycle
         S_MOD: begin
            if (mod_try >= {1'b0, n_ff}) begin
               mod_rem_in = CW'(mod_try - {1'b0, n_ff});
            end else begin
               mod_rem_in = CW'(mod_try);
            end
            mod_src_in = mod_src_ff << 1;
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(IW - 1)) begin
               idx_in = IW'(mod_rem_in); near_in = IW'(mod_rem_in);
               addr_in = IW'(mod_rem_in);
               cnt_in = '0; have_in = 1'b0;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: state_in = S_SRCH_MUL;
         S_SRCH_MUL: begin
            sq_a_in = ex_sq; sq_b_in = ey_sq;
            state_in = S_SRCH_CMP;
         end
         // nearest search over the window, first minimum wins
         S_SRCH_CMP: begin
            if (search_upd) begin
               best_in = sq_sum;
            end
            have_in = 1'b1;
            near_in = near_new;
            cnt_in = cnt_ff + KW'(1);
            if ((cnt_ff + KW'(1)) == KW'(win_ff)) begin
               last_near_in = near_new;
               addr_in = near_new;
               state_in = S_WALK_RD0;
            end else begin
               idx_in = wrap_next(idx_ff, n_ff);
               addr_in = wrap_next(idx_ff, n_ff);
               state_in = S_SRCH_RD;
            end
         end
         S_WALK_RD0: state_in = S_WALK_PREV;
         S_WALK_PREV: begin
            prev_x_in = rd_q_ff.x; prev_y_in = rd_q_ff.y;
            idx_in = wrap_next(near_ff, n_ff);
            addr_in = wrap_next(near_ff, n_ff);
            cnt_in = '0; acc_in = '0; la_in = la_calc;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: state_in = S_WALK_MUL;
         S_WALK_MUL: begin
            sq_a_in = ex_sq; sq_b_in = ey_sq;
            prev_x_in = rd_q_ff.x; prev_y_in = rd_q_ff.y;
            state_in = S_WALK_SUM;
         end
         S_WALK_SUM: begin
            sq_v_in = 58'(sq_sum) << 8;
            sq_r_in = '0;
            sq_bit_in = 58'(1) << 56;
            state_in = S_SQRT;
         end
         // floor square root, one result bit a cycle
         S_SQRT: begin
            if (sq_v_ff >= sq_try) begin
               sq_v_in = sq_v_ff - sq_try;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) state_in = S_WALK_ACC;
         end
         S_WALK_ACC: begin
            acc_in = acc_new;
            if (la_hit) begin
               target_in = idx_ff; addr_in = idx_ff;
               state_in = S_TGT_RD;
            end else if ((cnt_ff + KW'(1)) == KW'(n_ff)) begin
               target_in = near_ff; addr_in = near_ff;
               state_in = S_TGT_RD;
            end else begin
               cnt_in = cnt_ff + KW'(1);
               idx_in = wrap_next(idx_ff, n_ff);
               addr_in = wrap_next(idx_ff, n_ff);
               state_in = S_WALK_RD;
            end
         end
         S_TGT_RD: state_in = S_TGT;
         S_TGT: begin
            tx_in = rd_q_ff.x; ty_in = rd_q_ff.y;
            dx_in = ex; dy_in = ey;
            sq_a_in = ex_sq; sq_b_in = ey_sq;
            state_in = S_L2;
         end
         S_L2: begin
            l2_in = sq_sum;
            if (sq_sum > 51'd1) begin
               cx_in = rx0; cy_in = ry0; cz_in = cz0; cnt_in = '0;
               state_in = S_ROT;
            end else begin
               steer_in = '0; addr_in = '0;
               state_in = S_SPD_RD0;
            end
         end
         // rotate the offset into the vehicle frame
         S_ROT: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - cy_sh; cy_in = cy_ff + cx_sh; cz_in = cz_ff - atan_s;
            end else begin
               cx_in = cx_ff + cy_sh; cy_in = cy_ff - cx_sh; cz_in = cz_ff + atan_s;
            end
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(pps_pkg::CORDIC_STEPS - 1)) state_in = S_LYMUL;
         end
         S_LYMUL: begin
            pp_lo_in = 44'(cy_ff[19:0]) * 44'(pps_pkg::CORDIC_GAIN_Q24);
            pp_hi_in = gain_mul;
            state_in = S_LYSUM;
         end
         S_LYSUM: begin
            ly_in = 40'(ly_prod >>> 24);
            state_in = S_NUMMUL;
         end
         S_NUMMUL: begin
            np_lo_in = 37'(ly_ff[19:0]) * 37'({wb_ff, 1'b0});
            np_hi_in = wb_mul;
            state_in = S_NUMSUM;
         end
         S_NUMSUM: begin
            vn_in = num_prod;
            vd_in = $signed(64'(l2_ff) << 8);
            state_in = S_NORM;
         end
         // double both operands until one reaches 2^56
         S_NORM: begin
            if (vn_abs < 64'sh0100000000000000 && vd_ff < 64'sh0100000000000000) begin
               vn_in = vn_ff <<< 1; vd_in = vd_ff <<< 1;
            end else begin
               vz_in = '0; cnt_in = '0;
               state_in = S_VEC;
            end
         end
         // vectoring: angle of (d, n)
         S_VEC: begin
            if (!vn_ff[63]) begin
               vd_in = vd_ff + vn_sh; vn_in = vn_ff - vd_sh; vz_in = vz_ff + atan_s;
            end else begin
               vd_in = vd_ff - vn_sh; vn_in = vn_ff + vd_sh; vz_in = vz_ff - atan_s;
            end
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(pps_pkg::CORDIC_STEPS - 1)) begin
               addr_in = '0;
               state_in = S_SPD_RD0;
            end
         end
         S_SPD_RD0: begin
            // steering from the final angle, rounded to 16-bit units
            steer_in = (l2_ff > 51'd1) ? zr[31:16] : '0;
            state_in = S_SPD_T0;
         end
         S_SPD_T0: begin
            t0_in = rd_q_ff.time_ms;
            addr_in = IW'(n_ff - CW'(1));
            state_in = S_SPD_RDL;
         end
         S_SPD_RDL: state_in = S_SPD_TL;
         S_SPD_TL: begin
            if (elapsed >= t0_ff && elapsed <= rd_q_ff.time_ms) begin
               idx_in = '0; addr_in = '0;
               state_in = S_SPD_RD;
            end else begin
               spd_in = '0;
               state_in = S_DONE;
            end
         end
         S_SPD_RD: state_in = S_SPD_CMP;
         // first entry whose time reaches the elapsed time
         S_SPD_CMP: begin
            if (rd_q_ff.time_ms >= elapsed) begin
               spd_in = cap_speed(rd_q_ff.v, max_spd_ff);
               state_in = S_DONE;
            end else if ((CW'(idx_ff) + CW'(1)) == n_ff) begin
               spd_in = '0;
               state_in = S_DONE;
            end else begin
               idx_in = IW'(CW'(idx_ff) + CW'(1));
               addr_in = IW'(CW'(idx_ff) + CW'(1));
               state_in = S_SPD_RD;
            end
         end
         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = '{steering: steer_ff, speed_command: spd_ff,
                               target_index: 10'(target_ff), target_x: tx_ff,
                               target_y: ty_ff, forced_stop: forced_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign zr = vz_ff + 34'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         la_min_ff <= 16'd500; la_gain_ff <= 16'd102; wb_ff <= 16'd330;
         max_spd_ff <= 17'd100000; wcount_ff <= '0; swin_ff <= 11'd500;
         last_near_ff <= '0; start_time_ff <= '0;
         started_ff <= 1'b0; goal_ff <= 1'b0; crash_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         la_min_ff <= la_min_in; la_gain_ff <= la_gain_in; wb_ff <= wb_in;
         max_spd_ff <= max_spd_in; wcount_ff <= wcount_in; swin_ff <= swin_in;
         last_near_ff <= last_near_in; start_time_ff <= start_time_in;
         started_ff <= started_in; goal_ff <= goal_in; crash_ff <= crash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff <= px_in; py_ff <= py_in; vel_ff <= vel_in; head_ff <= head_in;
      time_ff <= time_in; n_ff <= n_in; win_ff <= win_in;
      mod_src_ff <= mod_src_in; mod_rem_ff <= mod_rem_in; addr_ff <= addr_in;
      idx_ff <= idx_in; near_ff <= near_in; target_ff <= target_in; cnt_ff <= cnt_in;
      have_ff <= have_in; best_ff <= best_in; l2_ff <= l2_in;
      sq_a_ff <= sq_a_in; sq_b_ff <= sq_b_in;
      prev_x_ff <= prev_x_in; prev_y_ff <= prev_y_in; la_ff <= la_in; acc_ff <= acc_in;
      sq_v_ff <= sq_v_in; sq_r_ff <= sq_r_in; sq_bit_ff <= sq_bit_in;
      tx_ff <= tx_in; ty_ff <= ty_in; dx_ff <= dx_in; dy_ff <= dy_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; ly_ff <= ly_in;
      pp_lo_ff <= pp_lo_in; pp_hi_ff <= pp_hi_in; np_lo_ff <= np_lo_in; np_hi_ff <= np_hi_in;
      vn_ff <= vn_in; vd_ff <= vd_in; vz_ff <= vz_in; t0_ff <= t0_in;
      steer_ff <= steer_in; spd_ff <= spd_in; forced_ff <= forced_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== tb/sv/pure_pursuit_steering_with_speed_replay_tb.sv =====
// Self-checking bench for the pure pursuit tracker: waypoint loads, odometry, flags.
// Depends on pps_pkg, the channel interfaces of pps_if.sv and the top level RTL.
module pure_pursuit_steering_with_speed_replay_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   localparam int  DEPTH        = 1024;
   localparam int  WATCHDOG_MAX = 200000;
   localparam int  DRAIN_CYCLES = 300;
   localparam int  HOLD_CYCLES  = 3000;
   localparam int  HOLD_AT_RSP  = 40;
   localparam longint QTR       = 64'sh40000000;
   localparam longint LIM56     = 64'sh0100000000000000;
   localparam longint ROT_GAIN  = 64'sd10188013;
   localparam longint ANG [0:19] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518};

   logic clock;
   logic reset;

   pps_req_if req_ch ();
   pps_rsp_if rsp_ch ();
   pps_csr_if csr_ch ();

   pure_pursuit_steering_with_speed_replay u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Tracker model state
   logic [31:0] m_time [DEPTH];
   longint      m_x [DEPTH];
   longint      m_y [DEPTH];
   longint      m_v [DEPTH];
   int unsigned m_last_nearest;
   logic [31:0] m_start_time;
   bit          m_started, m_goal, m_crash;
   int unsigned m_la_min, m_la_gain, m_wheelbase, m_max_speed, m_count, m_window;

   req_word_type pending_q [$];
   rsp_word_type cmd_expect_q [$];
   int           err_count;
   int           rsp_seen;

   // Generator-side copy of the path, used only to aim odometry samples
   longint      g_x [DEPTH];
   longint      g_y [DEPTH];
   longint      g_t [DEPTH];
   int          g_filled;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000000000000000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // y of (dx,dy) rotated by -heading, mm Q8
   function automatic longint vehicle_frame_y(longint dx, longint dy, logic [15:0] hdg);
      longint x, y, t, z, xs, ys;
      logic [31:0] zu;
      x = dx * 256;
      y = dy * 256;
      zu = 32'd0 - {hdg, 16'd0};
      z = longint'($signed(zu));
      if (z > QTR) begin
         t = x; x = -y; y = t; z = z - QTR;
      end else if (z < -QTR) begin
         t = x; x = y; y = -t; z = z + QTR;
      end
      for (int i = 0; i < 20; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ANG[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ANG[i];
         end
      end
      return (y * ROT_GAIN) >>> 24;
   endfunction

   // atan2(n, d), d > 0, 2^32 units per turn
   function automatic longint steer_angle32(longint n, longint d);
      longint z, ds, ns;
      z = 0;
      while (((n < 0) ? -n : n) < LIM56 && d < LIM56) begin
         n = n * 2;
         d = d * 2;
      end
      for (int i = 0; i < 20; i++) begin
         ds = d >>> i;
         ns = n >>> i;
         if (n >= 0) begin
            d = d + ns; n = n - ds; z = z + ANG[i];
         end else begin
            d = d - ns; n = n + ds; z = z - ANG[i];
         end
      end
      return z;
   endfunction

   // Apply one accepted request word to the model; queue the command it produces
   function automatic void track_request(req_word_type w);
      int unsigned n, win, nearest, target, idx, a, b;
      longint best, d, ex, ey, la, acc, sx, sy, dx, dy, l2, steer, spd;
      logic [31:0] elapsed;
      bit have;
      rsp_word_type r;
      case (w.action)
         ACT_WAYPOINT: begin
            m_time[w.waypoint_index] = w.time_ms;
            m_x[w.waypoint_index] = longint'(w.pos_x);
            m_y[w.waypoint_index] = longint'(w.pos_y);
            m_v[w.waypoint_index] = longint'(w.velocity);
            return;
         end
         ACT_GOAL: begin
            m_goal = w.flag_value;
            return;
         end
         ACT_CRASH: begin
            m_crash = w.flag_value;
            return;
         end
         default: ;
      endcase
      r = '0;
      if (m_goal || m_crash) begin
         r.forced_stop = 1'b1;
         cmd_expect_q.push_back(r);
         return;
      end
      n = (m_count > DEPTH) ? DEPTH : m_count;
      if (n == 0) return;
      if (!m_started) begin
         m_start_time = w.time_ms;
         m_started = 1'b1;
      end
      // nearest point search
      win = (m_window == 0) ? 1 : m_window;
      nearest = m_last_nearest % n;
      have = 1'b0;
      best = 0;
      for (int unsigned i = 0; i < win; i++) begin
         idx = (m_last_nearest + i) % n;
         ex = m_x[idx] - longint'(w.pos_x);
         ey = m_y[idx] - longint'(w.pos_y);
         d = ex * ex + ey * ey;
         if (!have || d < best) begin
            best = d; nearest = idx; have = 1'b1;
         end
      end
      m_last_nearest = nearest;
      // walk forward to the lookahead distance
      la = longint'(m_la_min) * 256 + longint'(m_la_gain) * longint'(w.velocity);
      target = nearest;
      acc = 0;
      for (int unsigned i = 0; i < n; i++) begin
         a = (nearest + i) % n;
         b = (a + 1) % n;
         sx = m_x[b] - m_x[a];
         sy = m_y[b] - m_y[a];
         acc = acc + longint'(int_sqrt(longint'(sx * sx + sy * sy) * 256));
         if (acc * 16 >= la) begin
            target = b;
            break;
         end
      end
      dx = m_x[target] - longint'(w.pos_x);
      dy = m_y[target] - longint'(w.pos_y);
      l2 = dx * dx + dy * dy;
      steer = 0;
      if (l2 > 1)
         steer = (steer_angle32(2 * longint'(m_wheelbase) * vehicle_frame_y(dx, dy, w.heading),
                                l2 * 256) + 32768) >>> 16;
      // time-replayed speed
      elapsed = w.time_ms - m_start_time;
      spd = 0;
      if (elapsed >= m_time[0] && elapsed <= m_time[n-1]) begin
         for (int unsigned i = 0; i < n; i++) begin
            if (m_time[i] >= elapsed) begin
               spd = m_v[i];
               break;
            end
         end
      end
      if (m_max_speed > 0 && spd > longint'(m_max_speed)) spd = longint'(m_max_speed);
      if (spd < 0) spd = 0;
      r.steering = steer[15:0];
      r.speed_command = spd[14:0];
      r.target_index = target[9:0];
      r.target_x = m_x[target][23:0];
      r.target_y = m_y[target][23:0];
      cmd_expect_q.push_back(r);
   endfunction

   // Request driver: bursts with random gaps
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            track_request(pending_q.pop_front());
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.word <= pending_q[0];
               if (burst_left == 0)
                  burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 20)
                                                        : $urandom_range(8, 1);
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(6);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random ready pattern plus one long hold-off
   logic [7:0] stall_pat;
   int         pat_cyc, hold_left;
   bit         hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_pat = 8'hFF;
         pat_cyc = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (cmd_expect_q.size() == 0) begin
               $error("command word with none expected");
               err_count++;
            end else begin
               rsp_word_type e;
               e = cmd_expect_q.pop_front();
               if (rsp_ch.word.steering !== e.steering) begin
                  $error("steering exp %0d got %0d", e.steering, rsp_ch.word.steering);
                  err_count++;
               end
               if (rsp_ch.word.speed_command !== e.speed_command) begin
                  $error("speed_command exp %0d got %0d", e.speed_command,
                         rsp_ch.word.speed_command);
                  err_count++;
               end
               if (rsp_ch.word.target_index !== e.target_index) begin
                  $error("target_index exp %0d got %0d", e.target_index,
                         rsp_ch.word.target_index);
                  err_count++;
               end
               if (rsp_ch.word.target_x !== e.target_x) begin
                  $error("target_x exp %0d got %0d", e.target_x, rsp_ch.word.target_x);
                  err_count++;
               end
               if (rsp_ch.word.target_y !== e.target_y) begin
                  $error("target_y exp %0d got %0d", e.target_y, rsp_ch.word.target_y);
                  err_count++;
               end
               if (rsp_ch.word.forced_stop !== e.forced_stop) begin
                  $error("forced_stop exp %0d got %0d", e.forced_stop,
                         rsp_ch.word.forced_stop);
                  err_count++;
               end
            end
         end
         if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         pat_cyc++;
         if (pat_cyc % 64 == 0)
            stall_pat = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= stall_pat[pat_cyc % 8];
         end
      end
   end

   // Watchdog: cycles without any accepted word
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_LA_MIN:     m_la_min = val[15:0];
         CSR_LA_GAIN:    m_la_gain = val[15:0];
         CSR_WHEELBASE:  m_wheelbase = val[15:0];
         CSR_MAX_SPEED:  m_max_speed = val[16:0];
         CSR_WP_COUNT:   m_count = val[10:0];
         CSR_SEARCH_WIN: m_window = val[10:0];
         default: ;
      endcase
   endtask

   function automatic void push_waypoint(int idx, longint t, longint x, longint y, longint v);
      req_word_type w;
      w = '0;
      w.action = ACT_WAYPOINT;
      w.waypoint_index = idx[9:0];
      w.time_ms = t[31:0];
      w.pos_x = x[23:0];
      w.pos_y = y[23:0];
      w.velocity = v[15:0];
      w.flag_value = 1'($urandom);
      w.heading = 16'($urandom);
      pending_q.push_back(w);
      g_x[idx] = x;
      g_y[idx] = y;
      g_t[idx] = t;
      if (idx == g_filled) g_filled++;
   endfunction

   function automatic void push_odometry(longint t, longint x, longint y, longint v,
                                         logic [15:0] hdg);
      req_word_type w;
      w = '0;
      w.action = ACT_ODOMETRY;
      w.waypoint_index = 10'($urandom);
      w.time_ms = t[31:0];
      w.pos_x = x[23:0];
      w.pos_y = y[23:0];
      w.velocity = v[15:0];
      w.heading = hdg;
      w.flag_value = 1'($urandom);
      pending_q.push_back(w);
   endfunction

   function automatic void push_flag(logic [1:0] act, bit val);
      req_word_type w;
      w = req_word_type'({$urandom, $urandom, $urandom, $urandom});
      w.action = act;
      w.flag_value = val;
      pending_q.push_back(w);
   endfunction

   function automatic longint rnd(longint lo, longint hi);
      return lo + longint'($urandom_range(32'(hi - lo)));
   endfunction

   // Load a path of n points starting at entry 0
   function automatic void load_path(int n, longint step_t);
      longint bx, by, sx, sy;
      bx = rnd(-1000000, 1000000);
      by = rnd(-1000000, 1000000);
      sx = rnd(-2000, 2000);
      sy = rnd(-2000, 2000);
      for (int i = 0; i < n; i++)
         push_waypoint(i, (($urandom_range(15) == 0) ? rnd(0, 3000) : i * step_t),
                       bx + i * sx + rnd(-300, 300), by + i * sy + rnd(-300, 300),
                       rnd(-500, 6000));
   endfunction

   // Mostly samples near the path with in-span times, some noise, waypoint rewrites and flag sequences
   function automatic void random_traffic(int items, int n);
      int j;
      bit is_goal;
      for (int k = 0; k < items; k++) begin
         j = $urandom_range(n - 1);
         case ($urandom_range(19))
            0, 1: push_waypoint($urandom_range(n - 1), g_t[j] + rnd(-50, 50),
                                g_x[j] + rnd(-200, 200), g_y[j] + rnd(-200, 200),
                                rnd(-32768, 32767));
            2: begin
               is_goal = $urandom_range(1);
               push_flag(is_goal ? ACT_GOAL : ACT_CRASH, 1'b1);
               push_odometry(longint'($urandom), rnd(-8388608, 8388607),
                             rnd(-8388608, 8388607), rnd(-32768, 32767), 16'($urandom));
               push_flag(is_goal ? ACT_GOAL : ACT_CRASH, 1'b0);
            end
            3: push_odometry(longint'($urandom), rnd(-8388608, 8388607),
                             rnd(-8388608, 8388607), rnd(-32768, 32767), 16'($urandom));
            default: push_odometry(1000 + g_t[j] + rnd(-150, 150), g_x[j] + rnd(-3000, 3000),
                                   g_y[j] + rnd(-3000, 3000), rnd(-2000, 20000),
                                   16'($urandom));
         endcase
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_ch.valid || cmd_expect_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.word = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      err_count = 0;
      rsp_seen = 0;
      g_filled = 0;
      m_last_nearest = 0;
      m_start_time = '0;
      m_started = 1'b0;
      m_goal = 1'b0;
      m_crash = 1'b0;
      m_la_min = 500;
      m_la_gain = 102;
      m_wheelbase = 330;
      m_max_speed = 100000;
      m_count = 0;
      m_window = 500;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table gives nothing; each flag forces a zero command even so
      push_odometry(1000, 0, 0, 0, 16'd0);
      push_flag(ACT_GOAL, 1'b1);
      push_odometry(1000, 5, 5, 100, 16'd0);
      push_flag(ACT_GOAL, 1'b0);
      push_flag(ACT_CRASH, 1'b1);
      push_odometry(1000, 5, 5, 100, 16'd0);
      push_flag(ACT_CRASH, 1'b0);
      // Short path with coincident points 3/4 and extreme corners
      push_waypoint(0, 0, 0, 0, 32767);
      push_waypoint(1, 100, 1000, 0, -32768);
      push_waypoint(2, 200, 2000, 1000, 1500);
      push_waypoint(3, 300, 3000, 3000, 800);
      push_waypoint(4, 400, 3000, 3000, 0);
      push_waypoint(5, 500, 8388607, 8388607, 100);
      push_waypoint(6, 600, -8388608, -8388608, 200);
      push_waypoint(7, 64'hFFFFFFFF, -8388608, 8388607, 300);
      wait_idle();

      // Zero lookahead, zero window, minimum wheelbase, no speed cap
      write_reg(CSR_WP_COUNT, 8);
      write_reg(CSR_SEARCH_WIN, 0);
      write_reg(CSR_LA_MIN, 0);
      write_reg(CSR_LA_GAIN, 0);
      write_reg(CSR_WHEELBASE, 1);
      write_reg(CSR_MAX_SPEED, 0);
      write_reg(8'd9, 32'hFFFFFFFF);
      @(negedge clock);
      push_odometry(1000, 1000, 0, 0, 16'd0);
      push_odometry(1100, 1001, 0, 0, 16'd16384);
      push_odometry(1200, 1001, 1, 0, 16'd32768);
      push_odometry(1350, 500, -200, 32767, 16'd49152);
      push_odometry(1600, 2000, 500, -32768, 16'd65535);
      wait_idle();

      // Maximum lookahead, wheelbase, cap and window
      write_reg(CSR_LA_MIN, 65535);
      write_reg(CSR_LA_GAIN, 65535);
      write_reg(CSR_WHEELBASE, 65535);
      write_reg(CSR_MAX_SPEED, 131071);
      write_reg(CSR_SEARCH_WIN, 2047);
      @(negedge clock);
      push_odometry(0, 8388607, -8388608, -32768, 16'd65535);
      push_odometry(64'hFFFFFFFF, -8388608, 8388607, 32767, 16'd1);
      push_odometry(1500, 3000, 2999, 12000, 16'd8192);
      push_odometry(1000, -3000, 3000, 0, 16'd40000);
      wait_idle();

      // Random paths under varied settings; the count shrinks below the last index too
      for (int ph = 0; ph < 4; ph++) begin
         n = (ph == 1) ? 2 : $urandom_range(24, 3);
         load_path(n, rnd(20, 400));
         wait_idle();
         write_reg(CSR_WP_COUNT, n);
         write_reg(CSR_SEARCH_WIN, (ph == 2) ? 0 : $urandom_range(n + 3, 1));
         write_reg(CSR_LA_MIN, (ph == 3) ? 65535 : $urandom_range(5000));
         write_reg(CSR_LA_GAIN, $urandom_range(2000));
         write_reg(CSR_WHEELBASE, $urandom_range(3000, 1));
         write_reg(CSR_MAX_SPEED, (ph == 0) ? 0 : $urandom_range(6000, 500));
         @(negedge clock);
         random_traffic(30, n);
         wait_idle();
      end

      // Full table with an oversized count
      load_path(DEPTH, 10);
      wait_idle();
      write_reg(CSR_WP_COUNT, 2047);
      write_reg(CSR_SEARCH_WIN, 1024);
      write_reg(CSR_LA_MIN, 65535);
      @(negedge clock);
      random_traffic(4, DEPTH);
      wait_idle();

      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
